FILE: src/hex_word_list_loader_macros.svh
// assertion macros for the hex word list loader
// clocked on clk, disabled while rst_n is low; no other dependencies
`ifndef HEX_WORD_LIST_LOADER_MACROS_SVH
`define HEX_WORD_LIST_LOADER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define HWL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define HWL_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`else
`define HWL_ASSERT(lbl, prop, msg)
`define HWL_ALWAYS(lbl, expr, msg)
`endif

`endif

FILE: src/hwl_pkg.sv
// shared constants and helpers for the hex word list loader
// status codes, character codes, character classes and the default pattern
package hwl_pkg;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_NONE = 3'd1;
    localparam logic [2:0] ST_MANY = 3'd2;
    localparam logic [2:0] ST_BAD  = 3'd3;
    localparam logic [2:0] ST_LONG = 3'd4;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    localparam logic [4:0] TOKEN_MAX_DIGITS = 5'd16;
    localparam logic [4:0] TOKEN_CHARS_SAT  = 5'd17;

    localparam logic REPORT_PARSE = 1'b0;
    localparam logic REPORT_READ  = 1'b1;

    // comma, semicolon, space, tab, lf, vt, ff, cr
    function automatic logic hwl_is_sep(input logic [7:0] c);
        return (c == 8'h2C) || (c == 8'h3B) || (c == 8'h20) ||
               ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // bit 4 set when the character is a hex digit, nibble in the low bits
    function automatic logic [4:0] hwl_hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if ((c >= 8'h30) && (c <= 8'h39))
            r = {1'b1, 4'(c - 8'h30)};
        else if ((c >= 8'h61) && (c <= 8'h66))
            r = {1'b1, 4'(c - 8'h57)};
        else if ((c >= 8'h41) && (c <= 8'h46))
            r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    // diagonal word: bits 63-p and 62-p, bit 0 standing in for the missing one
    function automatic logic [63:0] hwl_diag_word(input logic [5:0] pos);
        logic [63:0] hi;
        logic [63:0] lo;
        hi = 64'h8000_0000_0000_0000 >> pos;
        lo = (pos != 6'd63) ? (64'h4000_0000_0000_0000 >> pos) : 64'd1;
        return hi | lo;
    endfunction

endpackage

FILE: src/hex_word_list_loader.sv
// hex word list loader: a text message becomes a list of 64-bit pattern words
// uses hwl_pkg and hex_word_list_loader_macros.svh
//
// Input items on s_axis: tuser is the mode (0 message byte, 1 read a stored word),
// tlast marks the final byte of a message, tdata carries the byte and the read index.
// Bytes are parsed into comma/space/semicolon/tab/cr/lf/vt/ff separated hex tokens of
// up to 16 digits with an optional 0x prefix; the words go into the staging bank of a
// two-bank store, and at the end of a clean message the banks swap.
// Output items on m_axis: one parse report per final byte (tuser 0) with the status
// and the active word count, and one item per read (tuser 1) with the stored word.
// Bytes without tlast give no output item.
// An accepted item goes into the input register, and its result is loaded from there
// into the output register, which drives m_axis_tvalid. The store has one write port
// and one registered read port, and a byte needs at most one write, so one item is taken
// every cycle unless an item with a result waits for the output register to be free.
// When m_axis_tready is low the output register holds; bytes that give no result keep
// flowing through the input register, but an item with a result waits in it and stalls input.
// Reset clears the parse state and makes the default diagonal pattern active, with
// MAX_WORDS words; no clearing pass is needed.
`include "hex_word_list_loader_macros.svh"

module hex_word_list_loader #(
    parameter int MAX_WORDS = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // data_byte[7:0], read_index[14:8], zero pad
    input  logic        s_axis_tuser,   // mode
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // status[2:0], word_count[10:3], word_value[74:11]
    output logic        m_axis_tuser    // report_kind
);
    import hwl_pkg::*;

    localparam int CW     = $clog2(MAX_WORDS + 1);
    localparam int ADDR_W = (MAX_WORDS > 1) ? $clog2(2 * MAX_WORDS) : 1;
    localparam int DEPTH  = 2 * MAX_WORDS;
    localparam int CMP_W  = (CW > 7) ? CW : 7;

    // input register
    logic        s1_valid_reg;
    logic        s1_mode_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_eom_reg;
    logic [6:0]  s1_idx_reg;

    // parse and bank state
    logic          active_bank_reg, active_bank_next;
    logic [CW-1:0] active_count_reg, active_count_next;
    logic [CW-1:0] staged_count_reg, staged_count_next;
    logic [63:0]   token_value_reg, token_value_next;
    logic [4:0]    token_chars_reg, token_chars_next;
    logic          tok_lead_reg, tok_lead_next;
    logic          tok_prefix_reg, tok_prefix_next;
    logic          tok_bad_reg, tok_bad_next;
    logic [2:0]    message_error_reg, message_error_next;
    logic          diag_reg, diag_next;

    // output register
    logic        out_valid_reg;
    logic        out_kind_reg;
    logic [2:0]  out_status_reg;
    logic [7:0]  out_count_reg;
    logic [63:0] out_value_reg;

    logic [63:0] pattern_mem [DEPTH];

    // working token after the byte is taken
    logic [63:0]       tk_value;
    logic [4:0]        tk_chars;
    logic              tk_lead;
    logic              tk_prefix;
    logic              tk_bad;
    logic              is_sep;
    logic [4:0]        nib;
    logic              do_close;
    logic [2:0]        report_status;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic              has_result;
    logic              s1_fire;
    logic              out_free;
    logic              in_range;
    logic              use_diag;
    logic              rd_mem;
    logic [63:0]       rd_alt;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign has_result    = s1_mode_reg || s1_eom_reg;
    assign s1_fire       = s1_valid_reg && (!has_result || out_free);
    assign s_axis_tready = !s1_valid_reg || s1_fire;

    assign in_range  = (CMP_W'(s1_idx_reg) < CMP_W'(active_count_reg)) &&
                       (CMP_W'(s1_idx_reg) < CMP_W'(MAX_WORDS));
    assign use_diag  = diag_reg && !active_bank_reg;
    assign mem_raddr = ADDR_W'(s1_idx_reg) +
                       (active_bank_reg ? ADDR_W'(MAX_WORDS) : ADDR_W'(0));
    assign mem_waddr = ADDR_W'(staged_count_reg) +
                       (active_bank_reg ? ADDR_W'(0) : ADDR_W'(MAX_WORDS));
    assign rd_mem    = s1_mode_reg && in_range && !use_diag;
    assign rd_alt    = (s1_mode_reg && in_range && use_diag) ?
                       hwl_diag_word(s1_idx_reg[5:0]) : 64'd0;

    always_comb
    begin
        active_bank_next   = active_bank_reg;
        active_count_next  = active_count_reg;
        staged_count_next  = staged_count_reg;
        token_value_next   = token_value_reg;
        token_chars_next   = token_chars_reg;
        tok_lead_next      = tok_lead_reg;
        tok_prefix_next    = tok_prefix_reg;
        tok_bad_next       = tok_bad_reg;
        message_error_next = message_error_reg;
        diag_next          = diag_reg;
        mem_we             = 1'b0;
        report_status      = message_error_reg;

        is_sep    = hwl_is_sep(s1_byte_reg);
        nib       = hwl_hex_nibble(s1_byte_reg);
        tk_value  = token_value_reg;
        tk_chars  = token_chars_reg;
        tk_lead   = tok_lead_reg;
        tk_prefix = tok_prefix_reg;
        tk_bad    = tok_bad_reg;
        do_close  = is_sep || s1_eom_reg;

        if (!is_sep)
        begin
            if ((tk_chars == 5'd1) && tk_lead && !tk_prefix &&
                ((s1_byte_reg == CH_LOW_X) || (s1_byte_reg == CH_UP_X)))
            begin
                // a leading 0 followed by x turns into a prefix
                tk_prefix = 1'b1;
                tk_chars  = 5'd0;
                tk_value  = 64'd0;
            end
            else
            begin
                if ((tk_chars == 5'd0) && !tk_prefix && (s1_byte_reg == CH_ZERO))
                    tk_lead = 1'b1;
                if (!nib[4])
                    tk_bad = 1'b1;
                else
                    tk_value = {tk_value[59:0], nib[3:0]};
                if (tk_chars < TOKEN_CHARS_SAT)
                    tk_chars = tk_chars + 5'd1;
            end
        end

        if (s1_fire && !s1_mode_reg)
        begin
            token_value_next = tk_value;
            token_chars_next = tk_chars;
            tok_lead_next    = tk_lead;
            tok_prefix_next  = tk_prefix;
            tok_bad_next     = tk_bad;

            if (do_close)
            begin
                if (((tk_chars != 5'd0) || tk_prefix) && (message_error_reg == ST_OK))
                begin
                    if (staged_count_reg >= CW'(MAX_WORDS))
                        message_error_next = ST_MANY;
                    else if (tk_chars > TOKEN_MAX_DIGITS)
                        message_error_next = ST_LONG;
                    else if (tk_bad || (tk_chars == 5'd0))
                        message_error_next = ST_BAD;
                    else
                    begin
                        mem_we            = 1'b1;
                        staged_count_next = staged_count_reg + CW'(1);
                    end
                end
                token_value_next = 64'd0;
                token_chars_next = 5'd0;
                tok_lead_next    = 1'b0;
                tok_prefix_next  = 1'b0;
                tok_bad_next     = 1'b0;
            end

            if (s1_eom_reg)
            begin
                report_status = message_error_next;
                if ((report_status == ST_OK) && (staged_count_next == '0))
                    report_status = ST_NONE;
                if (report_status == ST_OK)
                begin
                    active_bank_next  = !active_bank_reg;
                    active_count_next = staged_count_next;
                    // once bank 0 is refilled the default pattern is gone for good
                    if (active_bank_reg)
                        diag_next = 1'b0;
                end
                staged_count_next  = '0;
                message_error_next = ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            active_bank_reg   <= 1'b0;
            active_count_reg  <= CW'(MAX_WORDS);
            staged_count_reg  <= '0;
            token_value_reg   <= 64'd0;
            token_chars_reg   <= 5'd0;
            tok_lead_reg      <= 1'b0;
            tok_prefix_reg    <= 1'b0;
            tok_bad_reg       <= 1'b0;
            message_error_reg <= ST_OK;
            diag_reg          <= 1'b1;
        end
        else
        begin
            if (s_axis_tready)
                s1_valid_reg <= s_axis_tvalid;
            if (s1_fire && has_result)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            active_bank_reg   <= active_bank_next;
            active_count_reg  <= active_count_next;
            staged_count_reg  <= staged_count_next;
            token_value_reg   <= token_value_next;
            token_chars_reg   <= token_chars_next;
            tok_lead_reg      <= tok_lead_next;
            tok_prefix_reg    <= tok_prefix_next;
            tok_bad_reg       <= tok_bad_next;
            message_error_reg <= message_error_next;
            diag_reg          <= diag_next;
        end
    end

    // payload registers and the store
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            s1_mode_reg <= s_axis_tuser;
            s1_byte_reg <= s_axis_tdata[7:0];
            s1_eom_reg  <= s_axis_tlast;
            s1_idx_reg  <= s_axis_tdata[14:8];
        end
        if (s1_fire && has_result)
        begin
            out_kind_reg   <= s1_mode_reg ? REPORT_READ : REPORT_PARSE;
            out_status_reg <= s1_mode_reg ? ST_OK : report_status;
            out_count_reg  <= 8'(active_count_next);
            out_value_reg  <= rd_mem ? pattern_mem[mem_raddr] : rd_alt;
        end
        if (mem_we)
            pattern_mem[mem_waddr] <= tk_value;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {5'd0, out_value_reg, out_count_reg, out_status_reg};

    `HWL_ALWAYS(a_staged_bound, staged_count_reg <= CW'(MAX_WORDS), "staged count past capacity")
    `HWL_ALWAYS(a_active_nonzero, active_count_reg != '0, "active pattern became empty")
    `HWL_ALWAYS(a_chars_sat, token_chars_reg <= TOKEN_CHARS_SAT, "token length not saturated")
    `HWL_ALWAYS(a_err_code, (message_error_reg == ST_OK) || (message_error_reg == ST_MANY) || (message_error_reg == ST_BAD) || (message_error_reg == ST_LONG), "bad held error code")
    `HWL_ASSERT(a_report_out, s1_fire && !s1_mode_reg && s1_eom_reg |=> m_axis_tvalid && (m_axis_tuser == REPORT_PARSE), "final byte gave no parse report")

endmodule

FILE: sim/hwl_parse_checker.sv
// result checker for the hex word list loader: follows both stream channels,
// predicts each output item from the accepted input items and compares them
// depends on hwl_pkg for status codes, report kinds and character codes
module hwl_parse_checker #(
    parameter int MAX_WORDS = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // data_byte[7:0], read_index[14:8], zero pad
    input  logic        s_axis_tuser,   // mode
    input  logic        s_axis_tlast,   // end_of_message
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [79:0] m_axis_tdata,   // status[2:0], word_count[10:3], word_value[74:11]
    input  logic        m_axis_tuser,   // report_kind
    output int          fail_count,
    output int          results_due,
    output int          results_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import hwl_pkg::*;

    localparam int MAX_PRINTED = 20;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic [7:0]  count;
        logic [63:0] value;
    } loader_result_t;

    loader_result_t due_q[$];

    // two banks of words, bank_sel picks the one that reads see
    logic [63:0] pat_mem [0:2*MAX_WORDS-1];
    logic        bank_sel;
    int          live_words;
    int          staged_words;
    logic [63:0] tok_value;
    logic [4:0]  tok_chars;
    logic        tok_lead;
    logic        tok_prefix;
    logic        tok_bad;
    logic [2:0]  msg_err;

    function automatic logic is_delim(input logic [7:0] c);
        case (c)
            CH_COMMA, CH_SEMI, CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic int digit_value(input logic [7:0] c);
        if (c >= CH_ZERO && c <= 8'h39)
            return int'(c) - int'(CH_ZERO);
        if (c >= 8'h61 && c <= 8'h66)
            return int'(c) - 8'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46)
            return int'(c) - 8'h41 + 10;
        return -1;
    endfunction

    task automatic clear_token();
        tok_value  = '0;
        tok_chars  = '0;
        tok_lead   = 1'b0;
        tok_prefix = 1'b0;
        tok_bad    = 1'b0;
    endtask

    task automatic restore_reset();
        int w;
        logic [5:0] pos;
        for (w = 0; w < 2 * MAX_WORDS; w++)
            pat_mem[w] = '0;
        for (w = 0; w < MAX_WORDS; w++)
        begin
            pos = 6'(w % 64);
            pat_mem[w] = 64'd1 << (63 - pos);
            // the last diagonal position wraps its second bit round to bit 0
            if (pos != 6'd63)
                pat_mem[w] |= 64'd1 << (62 - pos);
            else
                pat_mem[w] |= 64'd1;
        end
        bank_sel     = 1'b0;
        live_words   = MAX_WORDS;
        staged_words = 0;
        msg_err      = ST_OK;
        clear_token();
    endtask

    task automatic close_word();
        if (tok_chars == 0 && !tok_prefix)
            return;
        // once the message has an error, later tokens are dropped
        if (msg_err == ST_OK)
        begin
            if (staged_words >= MAX_WORDS)
                msg_err = ST_MANY;
            else if (tok_chars > TOKEN_MAX_DIGITS)
                msg_err = ST_LONG;
            else if (tok_bad || tok_chars == 0)
                msg_err = ST_BAD;
            else
            begin
                pat_mem[(bank_sel ? 0 : MAX_WORDS) + staged_words] = tok_value;
                staged_words++;
            end
        end
        clear_token();
    endtask

    task automatic take_char(input logic [7:0] c);
        int nib;
        // a lone leading zero followed by x turns into the prefix
        if (tok_chars == 1 && tok_lead && !tok_prefix && (c == CH_LOW_X || c == CH_UP_X))
        begin
            tok_prefix = 1'b1;
            tok_chars  = '0;
            tok_value  = '0;
            return;
        end
        if (tok_chars == 0 && !tok_prefix && c == CH_ZERO)
            tok_lead = 1'b1;
        nib = digit_value(c);
        if (nib < 0)
            tok_bad = 1'b1;
        else
            tok_value = {tok_value[59:0], 4'(nib)};
        if (tok_chars < TOKEN_CHARS_SAT)
            tok_chars++;
    endtask

    task automatic predict_item(input logic rd, input logic [7:0] ch, input logic fin,
                                input logic [6:0] idx);
        loader_result_t r;
        logic [2:0] outcome;
        r = '0;
        if (rd)
        begin
            r.kind  = REPORT_READ;
            r.status = ST_OK;
            r.count = 8'(live_words);
            if (idx < live_words && idx < MAX_WORDS)
                r.value = pat_mem[(bank_sel ? MAX_WORDS : 0) + idx];
            due_q.push_back(r);
            return;
        end
        if (is_delim(ch))
            close_word();
        else
            take_char(ch);
        if (!fin)
            return;
        close_word();
        outcome = msg_err;
        if (outcome == ST_OK && staged_words == 0)
            outcome = ST_NONE;
        if (outcome == ST_OK)
        begin
            bank_sel   = ~bank_sel;
            live_words = staged_words;
        end
        staged_words = 0;
        msg_err      = ST_OK;
        clear_token();
        r.kind   = REPORT_PARSE;
        r.status = outcome;
        r.count  = 8'(live_words);
        due_q.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_count++;
        if (fail_count <= MAX_PRINTED)
            $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
    endtask

    task automatic check_result();
        loader_result_t want;
        results_seen++;
        if (due_q.size() == 0)
        begin
            report_mismatch("output item with nothing expected", m_axis_tdata[63:0], '0);
            return;
        end
        want = due_q.pop_front();
        if (m_axis_tuser !== want.kind)
            report_mismatch("report_kind", 64'(m_axis_tuser), 64'(want.kind));
        if (m_axis_tdata[2:0] !== want.status)
            report_mismatch("status", 64'(m_axis_tdata[2:0]), 64'(want.status));
        if (m_axis_tdata[10:3] !== want.count)
            report_mismatch("word_count", 64'(m_axis_tdata[10:3]), 64'(want.count));
        if (m_axis_tdata[74:11] !== want.value)
            report_mismatch("word_value", m_axis_tdata[74:11], want.value);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restore_reset();
            due_q.delete();
            fail_count   = 0;
            results_seen = 0;
        end
        else
        begin
            // results first: an item taken at this edge cannot have its result out yet
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (s_axis_tvalid && s_axis_tready)
                predict_item(s_axis_tuser, s_axis_tdata[7:0], s_axis_tlast,
                             s_axis_tdata[14:8]);
        end
        results_due = due_q.size();
    end

endmodule

FILE: sim/tb_hex_word_list_loader.sv
// testbench top for the hex word list loader: clock, reset, stream stimulus and verdict
// depends on hwl_pkg, the loader rtl and hwl_parse_checker
module tb_hex_word_list_loader;
    timeunit 1ns;
    timeprecision 1ps;
    import hwl_pkg::*;

    localparam int MAX_WORDS    = 128;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 100;

    localparam logic [7:0] DELIMS [0:7] = '{8'h2C, 8'h3B, 8'h20, 8'h09,
                                           8'h0A, 8'h0B, 8'h0C, 8'h0D};

    typedef enum logic [1:0] {TOK_GOOD, TOK_BAD_CHAR, TOK_LONG, TOK_BARE} token_kind_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic        m_axis_tuser;

    int fail_count;
    int results_due;
    int results_seen;

    int burst_left;
    int items_sent;
    int messages;
    int reads;

    logic [7:0] text_q[$];

    hex_word_list_loader #(
        .MAX_WORDS(MAX_WORDS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    hwl_parse_checker #(
        .MAX_WORDS(MAX_WORDS)
    ) parse_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .fail_count   (fail_count),
        .results_due  (results_due),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("timeout with %0d results outstanding", results_due);
        $display("status: fail");
        $finish;
    end

    // receiver: a fresh random stall mask for each pass of its loop, sometimes no stalls at all
    initial
    begin
        logic [15:0] stall_mask;
        int phase;
        m_axis_tready = 1'b1;
        forever
        begin
            if ($urandom_range(0, 2) == 0)
                stall_mask = 16'hFFFF;
            else
                stall_mask = 16'($urandom) | 16'h0001;
            for (phase = 0; phase < 64; phase++)
            begin
                @(negedge clk);
                m_axis_tready = stall_mask[phase % 16];
            end
        end
    end

    function automatic logic [6:0] random_index();
        return ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 7)) : 7'($urandom);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
        if (n < 4'd10)
            return CH_ZERO + 8'(n);
        return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    // sender: bursts of items, random gaps between bursts
    task automatic push_item(input logic rd, input logic [7:0] ch, input logic fin,
                             input logic [6:0] idx);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {1'b0, idx, ch};
        s_axis_tuser  = rd;
        s_axis_tlast  = fin;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        burst_left--;
        items_sent++;
    endtask

    // byte and end mark are don't-care on a read, so they are left random
    task automatic send_read(input logic [6:0] idx);
        push_item(1'b1, 8'($urandom), 1'($urandom), idx);
        reads++;
    endtask

    task automatic send_queued(input int read_pct);
        int k;
        for (k = 0; k < text_q.size(); k++)
        begin
            if (k > 0 && $urandom_range(0, 99) < read_pct)
                send_read(random_index());
            push_item(1'b0, text_q[k], k == text_q.size() - 1, 7'($urandom));
        end
        text_q.delete();
        messages++;
    endtask

    task automatic send_text(input string txt);
        int k;
        for (k = 0; k < txt.len(); k++)
            text_q.push_back(txt[k]);
        send_queued(0);
    endtask

    task automatic add_delims(input int n);
        repeat (n) text_q.push_back(DELIMS[$urandom_range(0, 7)]);
    endtask

    task automatic add_token(input token_kind_t kind);
        int n;
        int k;
        logic [7:0] stray;
        if (kind == TOK_BARE || $urandom_range(0, 3) == 0)
        begin
            text_q.push_back(CH_ZERO);
            text_q.push_back($urandom_range(0, 1) ? CH_UP_X : CH_LOW_X);
        end
        if (kind == TOK_BARE)
            return;
        if (kind == TOK_LONG)
            n = $urandom_range(17, 20);
        else
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 16) : $urandom_range(1, 4);
        for (k = 0; k < n; k++)
            text_q.push_back(hex_char(4'($urandom), 1'($urandom)));
        // neither hex, separator nor x, so the token stays broken
        if (kind == TOK_BAD_CHAR || (kind == TOK_LONG && $urandom_range(0, 1) == 1))
        begin
            case ($urandom_range(0, 2))
                0: stray = 8'($urandom_range(8'h67, 8'h77));
                1: stray = 8'($urandom_range(8'h80, 8'hFF));
                default: stray = 8'($urandom_range(8'h00, 8'h08));
            endcase
            text_q[text_q.size() - 1 - $urandom_range(0, n - 1)] = stray;
        end
    endtask

    task automatic queue_number_list(input int n);
        int k;
        for (k = 0; k < n; k++)
        begin
            // single digits keep a full-length list short
            text_q.push_back(hex_char(4'($urandom), 1'($urandom)));
            if (k < n - 1)
                add_delims(1);
        end
    endtask

    task automatic wait_drained();
        int guard;
        s_axis_tvalid = 1'b0;
        guard = 0;
        while (results_due != 0 && guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        string noise_chars;
        int random_goal;
        int sel;
        int ntok;
        int flaw_at;
        int t;
        token_kind_t flaw;

        noise_chars   = "0xX9aFg,; ";
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        burst_left    = 0;
        items_sent    = 0;
        messages      = 0;
        reads         = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part
        send_read(7'd0);
        send_read(7'h7F);
        send_text("0Xf;a");
        send_read(7'd1);
        send_read(7'd2);
        send_text(" \t");
        send_text("0x");
        send_text("q,1");
        send_text("0123456789abcdefZ");
        // read in the middle of a message, closed by vertical tab and form feed
        push_item(1'b0, 8'h37, 1'b0, 7'h7F);
        send_read(7'd0);
        push_item(1'b0, DELIMS[5], 1'b0, 7'd0);
        push_item(1'b0, DELIMS[6], 1'b1, 7'h55);
        messages++;
        push_item(1'b0, 8'hFF, 1'b1, 7'h2A);
        push_item(1'b0, 8'h00, 1'b0, 7'h00);
        push_item(1'b0, DELIMS[7], 1'b1, 7'h7F);
        send_text("1\n");
        messages += 2;
        wait_drained();

        // random part: mostly clean lists, some with one broken token, a little noise
        random_goal = items_sent + RANDOM_ITEMS;
        while (items_sent < random_goal)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_read(random_index());
                continue;
            end
            sel = $urandom_range(0, 9);
            if (sel == 9)
            begin
                if ($urandom_range(0, 1) == 0)
                    add_delims($urandom_range(1, 3));
                else
                    repeat ($urandom_range(1, 8))
                        text_q.push_back($urandom_range(0, 1) ? 8'($urandom) :
                                         noise_chars[$urandom_range(0, noise_chars.len() - 1)]);
            end
            else
            begin
                ntok    = $urandom_range(1, 6);
                flaw_at = (sel >= 7) ? $urandom_range(0, ntok - 1) : -1;
                flaw    = token_kind_t'($urandom_range(1, 3));
                if ($urandom_range(0, 3) == 0)
                    add_delims($urandom_range(1, 2));
                for (t = 0; t < ntok; t++)
                begin
                    add_token((t == flaw_at) ? flaw : TOK_GOOD);
                    if (t < ntok - 1)
                        add_delims($urandom_range(1, 2));
                end
                if ($urandom_range(0, 1) == 0)
                    add_delims($urandom_range(1, 2));
            end
            send_queued(8);
        end
        wait_drained();

        // a list one word longer than the store holds
        queue_number_list(MAX_WORDS + 1);
        send_queued(0);
        send_read(7'h7F);
        send_read(7'd0);

        wait_drained();
        $display("covered %0d items: %0d messages and %0d reads, %0d results checked",
                 items_sent, messages, reads, results_seen);
        if (results_due != 0)
            $display("%0d expected results never arrived", results_due);
        if (fail_count == 0 && results_due == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/hwl_pkg.sv
src/hex_word_list_loader.sv
sim/hwl_parse_checker.sv
sim/tb_hex_word_list_loader.sv
